// ===== sv/hrd_pkg.sv =====
// ----------------------------------------------------------------------------
// hrd_pkg
// shared types, character codes and match strings of the response deframer
// ----------------------------------------------------------------------------
package hrd_pkg;

   localparam int LINE_MAX_DEF = 128;

   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   // prefix patterns, stored already folded to lower case
   localparam int PAT_CONNECT   = 0;
   localparam int PAT_HTTP      = 1;
   localparam int PAT_NOCARRIER = 2;
   localparam int PAT_ERROR     = 3;
   localparam int PAT_NOANSWER  = 4;
   localparam int PAT_CLEN      = 5;
   localparam int PAT_TENC      = 6;
   localparam int PAT_COUNT     = 7;

   localparam int CLEN_OFF = 15;
   localparam int TENC_OFF = 18;
   localparam int SENT_LEN = 12;
   localparam int CHUNKED_LEN = 7;

   localparam logic [8*18-1:0] STR_CONNECT   = "connect";
   localparam logic [8*18-1:0] STR_HTTP      = "http/";
   localparam logic [8*18-1:0] STR_NOCARRIER = "no carrier";
   localparam logic [8*18-1:0] STR_ERROR     = "error";
   localparam logic [8*18-1:0] STR_NOANSWER  = "no answer";
   localparam logic [8*18-1:0] STR_CLEN      = "content-length:";
   localparam logic [8*18-1:0] STR_TENC      = "transfer-encoding:";
   localparam logic [8*18-1:0] STR_CHUNKED   = "chunked";
   localparam logic [8*18-1:0] STR_SENT      = "\r\nNO CARRIER";

   typedef enum logic [2:0] {
      NM_STATUS = 3'b001,
      NM_DEC    = 3'b010,
      NM_HEX    = 3'b100
   } num_mode_type;

   typedef struct packed {
      logic         clear;
      logic         step;
      num_mode_type mode;
   } scan_ctrl_type;

   typedef struct packed {
      logic [PAT_COUNT-1:0] pat_ok;
      logic                 chunk_found;
      logic                 digits_seen;
      logic [31:0]          value;
   } scan_result_type;

   function automatic logic [7:0] str_at(logic [8*18-1:0] s, logic [4:0] len,
                                         logic [4:0] k);
      logic [4:0] pos;
      pos = len - 5'd1 - k;
      return s[{pos, 3'b000} +: 8];
   endfunction

   function automatic logic [7:0] fold(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [4:0] pat_len(int p);
      case (p)
         PAT_CONNECT:   return 5'd7;
         PAT_HTTP:      return 5'd5;
         PAT_NOCARRIER: return 5'd10;
         PAT_ERROR:     return 5'd5;
         PAT_NOANSWER:  return 5'd9;
         PAT_CLEN:      return 5'd15;
         default:       return 5'd18;
      endcase
   endfunction

   function automatic logic [7:0] pat_byte(int p, logic [4:0] k);
      case (p)
         PAT_CONNECT:   return str_at(STR_CONNECT, 5'd7, k);
         PAT_HTTP:      return str_at(STR_HTTP, 5'd5, k);
         PAT_NOCARRIER: return str_at(STR_NOCARRIER, 5'd10, k);
         PAT_ERROR:     return str_at(STR_ERROR, 5'd5, k);
         PAT_NOANSWER:  return str_at(STR_NOANSWER, 5'd9, k);
         PAT_CLEN:      return str_at(STR_CLEN, 5'd15, k);
         default:       return str_at(STR_TENC, 5'd18, k);
      endcase
   endfunction

   function automatic logic [7:0] sent_byte(logic [3:0] k);
      return str_at(STR_SENT, 5'd12, {1'b0, k});
   endfunction

endpackage

// ===== sv/hrd_scan.sv =====
// ----------------------------------------------------------------------------
// hrd_scan
// one-character-per-step line scanner: prefix matches, keyword search, number
// ----------------------------------------------------------------------------
module hrd_scan import hrd_pkg::*; #(
   parameter int IW = 7
) (
   input  logic            clock,
   input  scan_ctrl_type   ctrl,
   input  logic [IW-1:0]   idx,
   input  logic [7:0]      ch,
   output scan_result_type res
);

   typedef enum logic [3:0] {
      NS_PRE   = 4'b0001,
      NS_BLANK = 4'b0010,
      NS_DIGIT = 4'b0100,
      NS_STOP  = 4'b1000
   } num_state_type;

   logic [PAT_COUNT-1:0] ok_ff, ok_in;
   logic [2:0]           chm_ff, chm_in;
   logic                 found_ff, found_in;
   logic                 cstop_ff, cstop_in;
   num_state_type        ns_ff, ns_in;
   num_mode_type         mode_ff;
   logic [31:0]          val_ff, val_in;
   logic                 dig_ff, dig_in;

   logic [7:0]  fc;
   logic        is_dec, is_hex, is_digit, num_active;
   logic [3:0]  dval;
   logic [31:0] acc;

   always_comb begin
      fc = fold(ch);
      is_dec = (ch >= "0" && ch <= "9");
      is_hex = is_dec || (fc >= "a" && fc <= "f");
      is_digit = (mode_ff == NM_HEX) ? is_hex : is_dec;
      dval = is_dec ? 4'(ch - "0") : 4'(fc - "a" + 8'd10);
      acc = (mode_ff == NM_HEX) ? {val_ff[27:0], dval}
                                : (val_ff << 3) + (val_ff << 1) + 32'(dval);
      num_active = (mode_ff == NM_DEC) ? (idx >= IW'(CLEN_OFF)) : 1'b1;

      ok_in = ok_ff;
      chm_in = chm_ff;
      found_in = found_ff;
      cstop_in = cstop_ff;
      ns_in = ns_ff;
      val_in = val_ff;
      dig_in = dig_ff;

      if (ctrl.step) begin
         for (int p = 0; p < PAT_COUNT; p++) begin
            if (idx < IW'(pat_len(p)))
               ok_in[p] = ok_ff[p] & (fc == pat_byte(p, idx[4:0]));
         end

         // keyword search over the value of the transfer-encoding header
         if (idx >= IW'(TENC_OFF) && !cstop_ff && !found_ff) begin
            if (ch == 8'h00) begin
               cstop_in = 1'b1;
            end else if (fc == str_at(STR_CHUNKED, 5'(CHUNKED_LEN), {2'b00, chm_ff})) begin
               if (chm_ff == 3'(CHUNKED_LEN - 1)) found_in = 1'b1;
               chm_in = chm_ff + 3'd1;
            end else begin
               chm_in = (fc == "c") ? 3'd1 : 3'd0;
            end
         end

         if (num_active) begin
            case (ns_ff)
               NS_PRE: begin
                  if (ch == 8'h00) ns_in = NS_STOP;
                  else if (ch == CH_SP) ns_in = NS_BLANK;
               end
               NS_BLANK: begin
                  if (ch == CH_SP || ch == CH_TAB) begin
                     ns_in = NS_BLANK;
                  end else if (is_digit) begin
                     val_in = acc;
                     dig_in = 1'b1;
                     ns_in = NS_DIGIT;
                  end else begin
                     ns_in = NS_STOP;
                  end
               end
               NS_DIGIT: begin
                  if (is_digit) val_in = acc;
                  else ns_in = NS_STOP;
               end
               default: ns_in = NS_STOP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         ok_ff <= '1;
         chm_ff <= '0;
         found_ff <= 1'b0;
         cstop_ff <= 1'b0;
         ns_ff <= (ctrl.mode == NM_STATUS) ? NS_PRE : NS_BLANK;
         mode_ff <= ctrl.mode;
         val_ff <= '0;
         dig_ff <= 1'b0;
      end else begin
         ok_ff <= ok_in;
         chm_ff <= chm_in;
         found_ff <= found_in;
         cstop_ff <= cstop_in;
         ns_ff <= ns_in;
         val_ff <= val_in;
         dig_ff <= dig_in;
      end
   end

   assign res.pat_ok = ok_ff;
   assign res.chunk_found = found_ff;
   assign res.digits_seen = dig_ff;
   assign res.value = val_ff;

endmodule

// ===== sv/http_response_deframer.sv =====
// ----------------------------------------------------------------------------
// http_response_deframer
// extracts the http response body from a raw modem byte stream
// ----------------------------------------------------------------------------
// req channel: one raw modem byte per transfer on req_in_byte.
// rsp channel: one or more results per accepted byte; a byte that yields no
// body data gives a single result with rsp_byte_valid low. rsp_last_of_run
// marks the final result of a byte. phase, error code and status code show
// the state after the byte has been handled.
// header and chunk-size lines are collected in a line memory. on the line
// feed the line is walked one character at a time through the single
// scanner (memory read, then scanner step) over max(line length, 18)
// positions. req_ready is low while a byte is in work or its results wait.
// a stalled receiver simply holds the current result; nothing is dropped.
// reset (synchronous, active high) returns to waiting for the modem connect
// line with all counters cleared; the line memory needs no clearing since
// only the part below the current line length is ever read.
// ----------------------------------------------------------------------------
module http_response_deframer import hrd_pkg::*; #(
   parameter int LINE_MAX = LINE_MAX_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_body_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last_of_run,
   output logic [1:0]  rsp_phase,
   output logic [1:0]  rsp_error_code,
   output logic [15:0] rsp_http_status
);

   localparam int DEPTH = LINE_MAX - 1;
   localparam int AW = $clog2(DEPTH);
   localparam int IW = $clog2(LINE_MAX);

   // response parse phase
   typedef enum logic [10:0] {
      PP_CONNECT    = 11'b000_0000_0001,
      PP_STATUS     = 11'b000_0000_0010,
      PP_HEADERS    = 11'b000_0000_0100,
      PP_TRAILER    = 11'b000_0000_1000,
      PP_BODY_LEN   = 11'b000_0001_0000,
      PP_BODY_EOF   = 11'b000_0010_0000,
      PP_CHUNK_SIZE = 11'b000_0100_0000,
      PP_CHUNK_DATA = 11'b000_1000_0000,
      PP_CHUNK_CRLF = 11'b001_0000_0000,
      PP_DONE       = 11'b010_0000_0000,
      PP_ERROR      = 11'b100_0000_0000
   } parse_phase_type;

   // sequencer
   typedef enum logic [4:0] {
      S_IDLE    = 5'b00001,
      S_WALK_RD = 5'b00010,
      S_WALK_EV = 5'b00100,
      S_DECIDE  = 5'b01000,
      S_SEND    = 5'b10000
   } seq_state_type;

   localparam logic [1:0] ERR_REFUSED   = 2'd1;
   localparam logic [1:0] ERR_NO_STATUS = 2'd2;
   localparam logic [1:0] ERR_CHUNK     = 2'd3;

   seq_state_type   state_ff, state_in;
   parse_phase_type pp_ff, pp_in;
   logic [IW-1:0]   len_ff, len_in;
   logic [IW-1:0]   idx_ff, idx_in;
   logic [7:0]      last_ff, last_in;
   logic [15:0]     status_ff, status_in;
   logic [31:0]     blen_ff, blen_in;
   logic            lseen_ff, lseen_in;
   logic            chunked_ff, chunked_in;
   logic [31:0]     bcount_ff, bcount_in;
   logic [31:0]     crem_ff, crem_in;
   logic [3:0]      smatch_ff, smatch_in;
   logic [1:0]      fault_ff, fault_in;
   logic [3:0]      flush_ff, flush_in;   // held-back sentinel bytes to release
   logic            emitc_ff, emitc_in;   // input byte itself goes out
   logic [3:0]      k_ff, k_in;
   logic [7:0]      byte_ff, byte_in;

   logic [7:0]      mem [DEPTH];
   logic [7:0]      rdata_ff;
   logic            wr_en;

   scan_ctrl_type   sctrl;
   scan_result_type sres;
   logic [7:0]      scan_ch;

   logic            acc_in, acc_out;
   logic [3:0]      n_emit, n_res;
   logic [IW-1:0]   idx_nxt;
   logic [3:0]      m_nxt;
   logic [31:0]     crem_dec;

   assign acc_in = req_valid && req_ready;
   assign acc_out = rsp_valid && rsp_ready;
   assign idx_nxt = idx_ff + 1'b1;
   assign scan_ch = (idx_ff < len_ff) ? rdata_ff : 8'h00;

   hrd_scan #(.IW(IW)) u_scan (
      .clock(clock),
      .ctrl (sctrl),
      .idx  (idx_ff),
      .ch   (scan_ch),
      .res  (sres)
   );

   always_comb begin
      state_in = state_ff;
      pp_in = pp_ff;
      len_in = len_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      status_in = status_ff;
      blen_in = blen_ff;
      lseen_in = lseen_ff;
      chunked_in = chunked_ff;
      bcount_in = bcount_ff;
      crem_in = crem_ff;
      smatch_in = smatch_ff;
      fault_in = fault_ff;
      flush_in = flush_ff;
      emitc_in = emitc_ff;
      k_in = k_ff;
      byte_in = byte_ff;
      wr_en = 1'b0;
      sctrl.clear = 1'b0;
      sctrl.step = 1'b0;
      sctrl.mode = (pp_ff == PP_HEADERS) ? NM_DEC
                 : (pp_ff == PP_CHUNK_SIZE) ? NM_HEX : NM_STATUS;
      m_nxt = smatch_ff + 4'd1;
      crem_dec = crem_ff - 32'd1;

      case (state_ff)
         S_IDLE: begin
            if (acc_in) begin
               byte_in = req_in_byte;
               flush_in = '0;
               emitc_in = 1'b0;
               k_in = '0;
               state_in = S_SEND;
               case (pp_ff)
                  PP_CONNECT, PP_STATUS, PP_HEADERS, PP_TRAILER, PP_CHUNK_SIZE: begin
                     if (req_in_byte == CH_LF) begin
                        // drop one cr just before the lf, then walk the line
                        if (len_ff != '0 && last_ff == CH_CR) len_in = len_ff - 1'b1;
                        idx_in = '0;
                        sctrl.clear = 1'b1;
                        state_in = S_WALK_RD;
                     end else if (len_ff < IW'(DEPTH)) begin
                        wr_en = 1'b1;
                        len_in = len_ff + 1'b1;
                        last_in = req_in_byte;
                     end
                  end
                  PP_BODY_LEN: begin
                     emitc_in = 1'b1;
                     bcount_in = bcount_ff + 32'd1;
                     if (bcount_in >= blen_ff) pp_in = PP_DONE;
                  end
                  PP_BODY_EOF: begin
                     if (req_in_byte == sent_byte(smatch_ff)) begin
                        if (m_nxt == 4'(SENT_LEN)) begin
                           smatch_in = '0;
                           pp_in = PP_DONE;
                        end else begin
                           smatch_in = m_nxt;
                        end
                     end else if (smatch_ff == '0) begin
                        emitc_in = 1'b1;
                     end else begin
                        // partial sentinel broken: release it and retry from start
                        flush_in = smatch_ff;
                        if (req_in_byte == CH_CR) begin
                           smatch_in = 4'd1;
                        end else begin
                           smatch_in = '0;
                           emitc_in = 1'b1;
                        end
                     end
                  end
                  PP_CHUNK_DATA: begin
                     emitc_in = 1'b1;
                     bcount_in = bcount_ff + 32'd1;
                     crem_in = crem_dec;
                     if (crem_dec == '0) pp_in = PP_CHUNK_CRLF;
                  end
                  PP_CHUNK_CRLF: begin
                     if (req_in_byte == CH_LF) begin
                        len_in = '0;
                        pp_in = PP_CHUNK_SIZE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_WALK_RD: state_in = S_WALK_EV;
         S_WALK_EV: begin
            sctrl.step = 1'b1;
            if (idx_nxt < len_ff || idx_nxt < IW'(TENC_OFF)) begin
               idx_in = idx_nxt;
               state_in = S_WALK_RD;
            end else begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_SEND;
            len_in = '0;
            case (pp_ff)
               PP_CONNECT: begin
                  if (len_ff == '0) begin
                     pp_in = PP_CONNECT;
                  end else if (sres.pat_ok[PAT_CONNECT]) begin
                     pp_in = PP_STATUS;
                  end else if (sres.pat_ok[PAT_NOCARRIER] || sres.pat_ok[PAT_ERROR] ||
                               sres.pat_ok[PAT_NOANSWER]) begin
                     fault_in = ERR_REFUSED;
                     pp_in = PP_ERROR;
                  end else if (sres.pat_ok[PAT_HTTP]) begin
                     status_in = sres.value[15:0];
                     pp_in = PP_HEADERS;
                  end
               end
               PP_STATUS: begin
                  if (sres.pat_ok[PAT_HTTP]) begin
                     status_in = sres.value[15:0];
                     pp_in = PP_HEADERS;
                  end else if (len_ff != '0) begin
                     fault_in = ERR_NO_STATUS;
                     pp_in = PP_ERROR;
                  end
               end
               PP_HEADERS: begin
                  if (len_ff != '0) begin
                     if (sres.pat_ok[PAT_CLEN]) begin
                        blen_in = sres.value;
                        lseen_in = 1'b1;
                     end else if (sres.pat_ok[PAT_TENC] && sres.chunk_found) begin
                        chunked_in = 1'b1;
                     end
                  end else if (chunked_ff) begin
                     pp_in = PP_CHUNK_SIZE;
                  end else if (lseen_ff) begin
                     pp_in = (blen_ff == '0) ? PP_DONE : PP_BODY_LEN;
                  end else begin
                     pp_in = PP_BODY_EOF;
                  end
               end
               PP_TRAILER: begin
                  if (len_ff == '0) pp_in = PP_DONE;
               end
               PP_CHUNK_SIZE: begin
                  if (len_ff != '0) begin
                     if (!sres.digits_seen) begin
                        fault_in = ERR_CHUNK;
                        pp_in = PP_ERROR;
                     end else if (sres.value == '0) begin
                        pp_in = PP_TRAILER;
                     end else begin
                        crem_in = sres.value;
                        pp_in = PP_CHUNK_DATA;
                     end
                  end
               end
               default: ;
            endcase
         end
         S_SEND: begin
            if (acc_out) begin
               if (rsp_last_of_run) state_in = S_IDLE;
               else k_in = k_ff + 4'd1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pp_ff <= PP_CONNECT;
         len_ff <= '0;
         idx_ff <= '0;
         status_ff <= '0;
         blen_ff <= '0;
         lseen_ff <= 1'b0;
         chunked_ff <= 1'b0;
         bcount_ff <= '0;
         crem_ff <= '0;
         smatch_ff <= '0;
         fault_ff <= '0;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         pp_ff <= pp_in;
         len_ff <= len_in;
         idx_ff <= idx_in;
         status_ff <= status_in;
         blen_ff <= blen_in;
         lseen_ff <= lseen_in;
         chunked_ff <= chunked_in;
         bcount_ff <= bcount_in;
         crem_ff <= crem_in;
         smatch_ff <= smatch_in;
         fault_ff <= fault_in;
         k_ff <= k_in;
      end
   end

   // payload and line memory
   always_ff @(posedge clock) begin
      last_ff <= last_in;
      flush_ff <= flush_in;
      emitc_ff <= emitc_in;
      byte_ff <= byte_in;
      if (wr_en) mem[len_ff[AW-1:0]] <= req_in_byte;
      rdata_ff <= mem[idx_ff[AW-1:0]];
   end

   // result sequence: held-back sentinel bytes first, then the input byte
   assign n_emit = flush_ff + 4'(emitc_ff);
   assign n_res = (n_emit == '0) ? 4'd1 : n_emit;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_SEND);
   assign rsp_byte_valid = (n_emit != '0);
   assign rsp_body_byte = (n_emit == '0) ? 8'h00
                        : (k_ff < flush_ff) ? sent_byte(k_ff) : byte_ff;
   assign rsp_last_of_run = (k_ff == n_res - 4'd1);
   assign rsp_phase = (pp_ff == PP_DONE) ? 2'd1 : (pp_ff == PP_ERROR) ? 2'd2 : 2'd0;
   assign rsp_error_code = fault_ff;
   assign rsp_http_status = status_ff;

endmodule

// ===== sim/http_response_deframer_tb.sv =====
// ----------------------------------------------------------------------------
// http_response_deframer_tb
// self-checking bench: one modem session from connect wait through a
// chunked body to a bad chunk size stop, checked against a local predictor
// ----------------------------------------------------------------------------
// the block only leaves reset once, so the whole run is one session:
// a directed preamble (blank and unknown lines before connect, the connect
// line, a blank line before the status line), then a random response with
// mixed-case headers and random chunks of random byte values. the
// session ends with an illegal chunk size line, after which a few bytes
// must be ignored.
// ----------------------------------------------------------------------------
module http_response_deframer_tb;
   import hrd_pkg::*;

   localparam int LINE_KEEP = LINE_MAX_DEF - 1;

   // parse phases of the predictor
   typedef enum int {
      S_CONNECT, S_STATUS, S_HEADERS, S_TRAILER, S_BODY_LEN, S_BODY_EOF,
      S_CHUNK_SIZE, S_CHUNK_DATA, S_CHUNK_CRLF, S_DONE, S_ERROR
   } parse_state_type;

   // reported phase and error codes
   localparam logic [1:0] PH_RUN = 2'd0, PH_DONE = 2'd1, PH_STOP = 2'd2;
   localparam logic [1:0] ERR_NONE = 2'd0, ERR_REFUSED = 2'd1,
                          ERR_NO_STATUS = 2'd2, ERR_CHUNK_SIZE = 2'd3;

   typedef struct {
      logic [7:0]  body;
      logic        bvalid;
      logic        last;
      logic [1:0]  phase;
      logic [1:0]  err;
      logic [15:0] status;
   } body_result_type;

   typedef struct {
      logic [7:0] in_byte;
      bit         typed;   // expectation typed in the table
      logic [1:0] phase;
      logic [1:0] err;
      logic [15:0] status;
   } preamble_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_body_byte;
   logic        rsp_byte_valid;
   logic        rsp_last_of_run;
   logic [1:0]  rsp_phase;
   logic [1:0]  rsp_error_code;
   logic [15:0] rsp_http_status;

   http_response_deframer DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor
   parse_state_type pstate;
   logic [7:0]   line_mem [LINE_KEEP];
   int unsigned  held_count;
   logic [15:0]  status_reg;
   logic [31:0]  content_len;
   bit           length_known;
   bit           is_chunked;
   logic [31:0]  body_emitted;
   logic [31:0]  chunk_rest;
   int unsigned  eof_match;
   logic [1:0]   fault;

   body_result_type expected_bytes[$];

   string eof_marker = "\r\nNO CARRIER";

   function automatic logic [7:0] line_char(int unsigned i);
      if (i >= held_count || i >= LINE_KEEP) return 8'd0;
      return line_mem[i];
   endfunction

   function automatic logic [7:0] lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   function automatic bit line_has(int unsigned off, string pat);
      for (int i = 0; i < pat.len(); i++)
         if (lower(line_char(off + i)) != lower(pat[i])) return 0;
      return 1;
   endfunction

   function automatic int unsigned past_blanks(int unsigned i);
      while (line_char(i) == CH_SP || line_char(i) == CH_TAB) i++;
      return i;
   endfunction

   function automatic logic [31:0] decimal_at(int unsigned i);
      logic [31:0] v;
      v = 0;
      while (line_char(i) >= "0" && line_char(i) <= "9") begin
         v = v * 32'd10 + 32'(line_char(i) - "0");
         i++;
      end
      return v;
   endfunction

   // collect a byte; true once a whole line is held
   function automatic bit collect(logic [7:0] c);
      if (c == CH_LF) begin
         if (held_count > 0 && held_count <= LINE_KEEP && line_mem[held_count-1] == CH_CR)
            held_count--;
         return 1;
      end
      if (held_count < LINE_KEEP) begin
         line_mem[held_count] = c;
         held_count++;
      end
      return 0;
   endfunction

   function automatic void take_status();
      int unsigned s;
      s = 0;
      while (line_char(s) != 0 && line_char(s) != CH_SP) s++;
      status_reg = 16'(decimal_at(past_blanks(s)));
      pstate = S_HEADERS;
   endfunction

   function automatic void stop_with(logic [1:0] code);
      fault = code;
      pstate = S_ERROR;
   endfunction

   function automatic void clear_state();
      pstate = S_CONNECT;
      held_count = 0;
      status_reg = 0;
      content_len = 0;
      length_known = 0;
      is_chunked = 0;
      body_emitted = 0;
      chunk_rest = 0;
      eof_match = 0;
      fault = ERR_NONE;
   endfunction

   // work out the results one accepted byte causes and queue them
   function automatic void predict_byte(logic [7:0] c);
      logic [7:0]  emitted[$];
      bit          blank;
      logic [31:0] v;
      int unsigned i, m;
      int          digits, cnt;
      logic [7:0]  d;
      body_result_type r;

      case (pstate)
         S_CONNECT: if (collect(c)) begin
            if (held_count == 0) begin
            end else if (line_has(0, "CONNECT")) pstate = S_STATUS;
            else if (line_has(0, "NO CARRIER") || line_has(0, "ERROR") ||
                     line_has(0, "NO ANSWER")) stop_with(ERR_REFUSED);
            else if (line_has(0, "HTTP/")) take_status();
            held_count = 0;
         end
         S_STATUS: if (collect(c)) begin
            if (line_has(0, "HTTP/")) take_status();
            else if (held_count != 0) stop_with(ERR_NO_STATUS);
            held_count = 0;
         end
         S_HEADERS, S_TRAILER: if (collect(c)) begin
            blank = (held_count == 0);
            if (!blank && pstate == S_HEADERS) begin
               if (line_has(0, "content-length:")) begin
                  content_len = decimal_at(past_blanks(15));
                  length_known = 1;
               end else if (line_has(0, "transfer-encoding:")) begin
                  for (i = past_blanks(18); line_char(i) != 0; i++)
                     if (line_has(i, "chunked")) begin
                        is_chunked = 1;
                        break;
                     end
               end
            end
            held_count = 0;
            if (blank) begin
               if (pstate == S_TRAILER) pstate = S_DONE;
               else if (is_chunked) pstate = S_CHUNK_SIZE;
               else if (length_known) pstate = (content_len == 0) ? S_DONE : S_BODY_LEN;
               else pstate = S_BODY_EOF;
            end
         end
         S_BODY_LEN: begin
            emitted.push_back(c);
            body_emitted++;
            if (body_emitted >= content_len) pstate = S_DONE;
         end
         S_BODY_EOF: begin
            // held-back marker bytes are released once they cannot match
            forever begin
               m = eof_match % 12;
               if (c == eof_marker[m]) begin
                  m++;
                  if (m >= 12) begin
                     m = 0;
                     pstate = S_DONE;
                  end
                  eof_match = m;
                  break;
               end
               if (m == 0) begin
                  emitted.push_back(c);
                  break;
               end
               for (int k = 0; k < m && emitted.size() < 12; k++)
                  emitted.push_back(eof_marker[k]);
               eof_match = 0;
            end
            body_emitted += emitted.size();
         end
         S_CHUNK_SIZE: if (collect(c) && held_count != 0) begin
            v = 0;
            digits = 0;
            for (i = past_blanks(0); ; i++) begin
               d = line_char(i);
               if (d >= "0" && d <= "9") v = (v << 4) | 32'(d - "0");
               else if (d >= "a" && d <= "f") v = (v << 4) | 32'(d - "a" + 10);
               else if (d >= "A" && d <= "F") v = (v << 4) | 32'(d - "A" + 10);
               else break;
               digits++;
            end
            held_count = 0;
            if (digits == 0) stop_with(ERR_CHUNK_SIZE);
            else if (v == 0) pstate = S_TRAILER;
            else begin
               chunk_rest = v;
               pstate = S_CHUNK_DATA;
            end
         end
         S_CHUNK_DATA: begin
            emitted.push_back(c);
            body_emitted++;
            chunk_rest--;
            if (chunk_rest == 0) pstate = S_CHUNK_CRLF;
         end
         S_CHUNK_CRLF: if (c == CH_LF) begin
            held_count = 0;
            pstate = S_CHUNK_SIZE;
         end
         default: ;
      endcase

      cnt = (emitted.size() == 0) ? 1 : emitted.size();
      for (int k = 0; k < cnt; k++) begin
         r.body   = (emitted.size() == 0) ? 8'd0 : emitted[k];
         r.bvalid = (emitted.size() != 0);
         r.last   = (k == cnt - 1);
         r.phase  = (pstate == S_DONE) ? PH_DONE : (pstate == S_ERROR) ? PH_STOP : PH_RUN;
         r.err    = fault;
         r.status = status_reg;
         expected_bytes.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus
   logic [7:0] modem_bytes[$];
   int         directed_rows;
   int         errors = 0;
   int         results_seen = 0;
   int         body_seen = 0;
   int         hold_off = 0;
   bit         quiet = 0;

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) modem_bytes.push_back(s[i]);
   endfunction

   // directed preamble: expectations read straight off the connect-wait rules
   preamble_row_type preamble[$];

   function automatic void add_row(logic [7:0] b);
      preamble_row_type row;
      row.in_byte = b;
      row.typed = 1;
      row.phase = PH_RUN;
      row.err = ERR_NONE;
      row.status = 16'd0;
      preamble.push_back(row);
   endfunction

   function automatic void build_preamble();
      string s;
      s = {"\n", "q\n", "cOnNeCt\r\n", "\r\n"};   // blank, unknown, connect, blank
      for (int i = 0; i < s.len(); i++) add_row(s[i]);
   endfunction

   // random response: headers, then chunks of random bytes
   function automatic void build_response(int target);
      int n;
      add_text($sformatf("HTTP/1.%0d %0d OK\r\n", $urandom_range(1), $urandom_range(100, 599)));
      add_text($sformatf("Content-Length: %0d\r\n", $urandom_range(0, 999)));
      if ($urandom_range(1) == 1) add_text("transfer-ENCODING:  gzip, Chunked\r\n");
      else add_text("Transfer-Encoding:\tchunked\n");
      add_text("\r\n");
      while (modem_bytes.size() < target) begin
         n = $urandom_range(1, 12);
         add_text($urandom_range(3) == 0 ? $sformatf(" %0H;ext=1\r\n", n)
                                         : $sformatf("%0h\r\n", n));
         repeat (n) modem_bytes.push_back(8'($urandom_range(255)));
         add_text("\r\n");
      end
      add_text("zz\r\n");   // no hex digit: bad chunk size
      add_text("0\r\n\r\n");   // ignored after the stop
   endfunction

   task automatic offer_byte(logic [7:0] b, bit use_typed, preamble_row_type row);
      body_result_type r;
      @(negedge clock);
      while (!quiet && $urandom_range(99) < 12) @(negedge clock);
      req_valid = 1'b1;
      req_in_byte = b;
      do @(posedge clock); while (!req_ready);
      predict_byte(b);
      if (use_typed) begin
         // typed row replaces the predicted single result
         r = expected_bytes.pop_back();
         r.body = 8'd0;
         r.bvalid = 1'b0;
         r.last = 1'b1;
         r.phase = row.phase;
         r.err = row.err;
         r.status = row.status;
         expected_bytes.push_back(r);
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // receiver: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_ready = 1'b0;
            hold_off--;
         end else begin
            rsp_ready = quiet ? 1'b1 : ($urandom_range(99) >= 12);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      body_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (rsp_byte_valid) body_seen++;
         if (expected_bytes.size() == 0) begin
            $error("result with no expectation waiting");
            errors++;
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_body_byte !== e.body) begin
               $error("body_byte expected %h actual %h", e.body, rsp_body_byte);
               errors++;
            end
            if (rsp_byte_valid !== e.bvalid) begin
               $error("byte_valid expected %b actual %b", e.bvalid, rsp_byte_valid);
               errors++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run expected %b actual %b", e.last, rsp_last_of_run);
               errors++;
            end
            if (rsp_phase !== e.phase) begin
               $error("phase expected %0d actual %0d", e.phase, rsp_phase);
               errors++;
            end
            if (rsp_error_code !== e.err) begin
               $error("error_code expected %0d actual %0d", e.err, rsp_error_code);
               errors++;
            end
            if (rsp_http_status !== e.status) begin
               $error("http_status expected %0d actual %0d", e.status, rsp_http_status);
               errors++;
            end
         end
      end
   end

   initial begin
      preamble_row_type none;
      int               body_start;
      none.typed = 0;
      clear_state();
      build_preamble();
      directed_rows = preamble.size();
      build_response(88);
      body_start = -1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (preamble[i]) offer_byte(preamble[i].in_byte, preamble[i].typed, preamble[i]);

      foreach (modem_bytes[i]) begin
         quiet = (i >= 60 && i < 90);   // stretch with no idling on either side
         if (pstate == S_CHUNK_DATA && body_start < 0) begin
            body_start = i;
            hold_off = 60;   // receiver stalls; the sender waits on req_ready meanwhile
         end
         if (i == 40)   // sender waits until everything has drained
            while (expected_bytes.size() != 0) @(posedge clock);
         offer_byte(modem_bytes[i], 0, none);
      end
      quiet = 0;

      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("covered %0d directed and %0d random bytes, %0d results, %0d body bytes",
               directed_rows, modem_bytes.size(), results_seen, body_seen);
      $display("session ran connect, status, headers, chunked body, bad chunk size stop");
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #(20 * 400000);
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== http_response_deframer.f =====
sv/hrd_pkg.sv
sv/hrd_scan.sv
sv/http_response_deframer.sv
sim/http_response_deframer_tb.sv
